// ===== rtl/pes_pkg.sv =====
// Shared types, constants and the control ROM of the pulsed emitter burst sequencer.
// No dependencies; used by pes_ram and pulsed_emitter_burst_sequencer_core.
package pes_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int NUM_CHANNELS_DEF = 6;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_PERIOD = 2'd0;
    localparam logic [1:0] CFG_DRIVE  = 2'd1;
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    localparam logic [15:0] PERIOD_RST = 16'd1000;
    localparam logic [6:0]  DRIVE_RST  = 7'd50;
    localparam logic [15:0] SETTLE_RST = 16'd100;
    localparam logic [6:0]  DRIVE_MAX  = 7'd100;

    // command codes
    localparam logic [1:0] CMD_PUSH_R = 2'd0;
    localparam logic [1:0] CMD_PUSH_L = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_STOP   = 2'd3;

    // ceil(2^28 / 1000): floor(x / 1000) = (x * RECIP_1000) >> 28 for x < 2^18
    localparam logic [18:0] RECIP_1000 = 19'd268436;
    localparam int          RECIP_SHIFT = 28;
    localparam logic [16:0] DIV_255    = 17'd255;

    typedef struct packed {
        logic [2:0]  channel;
        logic [7:0]  intensity;
        logic [15:0] duration;
        logic [7:0]  level;
    } req_t;

    localparam int REQ_W = $bits(req_t);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SETTLE = 4'b0010,
        PH_ON     = 4'b0100,
        PH_OFF    = 4'b1000
    } phase_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_FETCH, OP_POP_RD, OP_POP_LD, OP_MUL, OP_FOLD0, OP_FOLD, OP_FIXQ,
        OP_ENTER_SETTLE, OP_ENTER_ON, OP_ENTER_OFF, OP_ACCUM, OP_SUBREM,
        OP_MULSEC, OP_DONE, OP_DEC, OP_PUSH, OP_STOP, OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER, C_ALWAYS, C_NO_BEAT, C_CMD_PUSH, C_CMD_STOP, C_BUSY, C_QEMPTY,
        C_REM_ZERO, C_SETTLE_SKIP, C_ONTIME_ZERO, C_OFF_ZERO, C_END, C_TIMER_NZ,
        C_PH_SETTLE, C_PH_ON, C_OUT_FREE
    } cond_t;

    localparam int UPC_W = 5;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    // entry points of the microprogram
    localparam logic [UPC_W-1:0] A_FETCH  = 5'd0;
    localparam logic [UPC_W-1:0] A_SETTLE = 5'd12;
    localparam logic [UPC_W-1:0] A_ON     = 5'd14;
    localparam logic [UPC_W-1:0] A_OFF    = 5'd16;
    localparam logic [UPC_W-1:0] A_END    = 5'd18;
    localparam logic [UPC_W-1:0] A_FIN    = 5'd20;
    localparam logic [UPC_W-1:0] A_TICK   = 5'd22;
    localparam logic [UPC_W-1:0] A_PUSH   = 5'd27;
    localparam logic [UPC_W-1:0] A_STOP   = 5'd28;
    localparam logic [UPC_W-1:0] A_EMIT   = 5'd29;

    // one control word per step: do op, then jump to target if cond holds, else fall through
    function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: A_FETCH};
        unique case (addr)
            5'd0:  w = '{op: OP_FETCH,        cond: C_NO_BEAT,     target: A_FETCH};
            5'd1:  w = '{op: OP_NOP,          cond: C_CMD_PUSH,    target: A_PUSH};
            5'd2:  w = '{op: OP_NOP,          cond: C_CMD_STOP,    target: A_STOP};
            5'd3:  w = '{op: OP_NOP,          cond: C_BUSY,        target: A_TICK};
            5'd4:  w = '{op: OP_NOP,          cond: C_QEMPTY,      target: A_EMIT};
            5'd5:  w = '{op: OP_POP_RD,       cond: C_NEVER,       target: A_FETCH};
            5'd6:  w = '{op: OP_POP_LD,       cond: C_NEVER,       target: A_FETCH};
            5'd7:  w = '{op: OP_MUL,          cond: C_NEVER,       target: A_FETCH};
            5'd8:  w = '{op: OP_FOLD0,        cond: C_NEVER,       target: A_FETCH};
            5'd9:  w = '{op: OP_FOLD,         cond: C_NEVER,       target: A_FETCH};
            5'd10: w = '{op: OP_FOLD,         cond: C_NEVER,       target: A_FETCH};
            5'd11: w = '{op: OP_FIXQ,         cond: C_REM_ZERO,    target: A_FIN};
            5'd12: w = '{op: OP_NOP,          cond: C_SETTLE_SKIP, target: A_ON};
            5'd13: w = '{op: OP_ENTER_SETTLE, cond: C_ALWAYS,      target: A_EMIT};
            5'd14: w = '{op: OP_NOP,          cond: C_ONTIME_ZERO, target: A_OFF};
            5'd15: w = '{op: OP_ENTER_ON,     cond: C_ALWAYS,      target: A_EMIT};
            5'd16: w = '{op: OP_NOP,          cond: C_OFF_ZERO,    target: A_END};
            5'd17: w = '{op: OP_ENTER_OFF,    cond: C_ALWAYS,      target: A_EMIT};
            5'd18: w = '{op: OP_ACCUM,        cond: C_END,         target: A_FIN};
            5'd19: w = '{op: OP_SUBREM,       cond: C_ALWAYS,      target: A_SETTLE};
            5'd20: w = '{op: OP_MULSEC,       cond: C_NEVER,       target: A_FETCH};
            5'd21: w = '{op: OP_DONE,         cond: C_ALWAYS,      target: A_EMIT};
            5'd22: w = '{op: OP_DEC,          cond: C_NEVER,       target: A_FETCH};
            5'd23: w = '{op: OP_NOP,          cond: C_TIMER_NZ,    target: A_EMIT};
            5'd24: w = '{op: OP_NOP,          cond: C_PH_SETTLE,   target: A_ON};
            5'd25: w = '{op: OP_NOP,          cond: C_PH_ON,       target: A_OFF};
            5'd26: w = '{op: OP_NOP,          cond: C_ALWAYS,      target: A_END};
            5'd27: w = '{op: OP_PUSH,         cond: C_ALWAYS,      target: A_EMIT};
            5'd28: w = '{op: OP_STOP,         cond: C_ALWAYS,      target: A_EMIT};
            5'd29: w = '{op: OP_EMIT,         cond: C_OUT_FREE,    target: A_FETCH};
            5'd30: w = '{op: OP_NOP,          cond: C_ALWAYS,      target: A_EMIT};
            default: w = '{op: OP_NOP,        cond: C_ALWAYS,      target: A_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pes_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on pes_pkg for default sizes.
module pes_ram #(
    parameter int WIDTH = pes_pkg::REQ_W,
    parameter int DEPTH = pes_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pulsed_emitter_burst_sequencer_core.sv =====
// Pulsed emitter burst sequencer: two request queues and a microcoded emission sequencer.
// Depends on pes_pkg (types, control ROM) and pes_ram (queue storage).
//
// Usage: s_ carries one command beat (push right, push left, 1 ms tick, stop) with its
// request fields; every input beat yields exactly one result beat on m_ with the
// relay/LED masks, PWM levels, busy and done flags and both queue counts after that
// command. Configuration (period, drive level, settle time) is written on cfg_ with
// cfg_wen, one register per cycle, while no beat is in flight.
// A microprogram in the control ROM runs one step per cycle. A push or stop decodes the
// command, acts on it and goes to the emit step; a tick inside a window decrements the
// timer first; a tick that pops a request or closes a window also walks the window checks.
// The next beat is accepted once the result is in the output register, while that
// result still waits for m_ready. If m_ready is low when the next result is ready, the
// sequencer holds at the emit step until the output register frees up.
// Reset (aresetn low, synchronous) empties both queues, stops any emission, drops a
// pending result and restores the configuration defaults. Queue contents are not
// cleared; the fill counts alone define what is valid.
module pulsed_emitter_burst_sequencer_core #(
    parameter int QUEUE_DEPTH  = pes_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_CHANNELS = pes_pkg::NUM_CHANNELS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wen,
    input  logic [1:0]                         cfg_index,
    input  logic [15:0]                        cfg_wdata,
    // command beats
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_cmd,
    input  logic [2:0]                         s_channel,
    input  logic [7:0]                         s_intensity,
    input  logic [15:0]                        s_duration_ms,
    input  logic [7:0]                         s_pod_level,
    // result beats
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [NUM_CHANNELS-1:0]            m_relay_mask,
    output logic [NUM_CHANNELS-1:0]            m_led_mask,
    output logic [6:0]                         m_pwm_right,
    output logic [6:0]                         m_pwm_left,
    output logic                               m_freq_fixed,
    output logic                               m_busy_res,
    output logic                               m_push_accepted,
    output logic                               m_done_res,
    output logic [2:0]                         m_done_channel,
    output logic [7:0]                         m_new_level,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   m_right_count,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   m_left_count
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam int SW = CW + 1;

    // configuration registers
    logic [15:0] period_reg, settle_reg;
    logic [6:0]  drive_reg;

    // sequencer
    logic [pes_pkg::UPC_W-1:0] upc_reg, upc_next;
    pes_pkg::ctrl_t            ctrl;
    logic                      jump;

    // latched command beat
    logic [1:0]    cmd_reg;
    pes_pkg::req_t in_req_reg;

    // queues
    logic [AW-1:0] r_head_reg, l_head_reg;
    logic [CW-1:0] r_fill_reg, l_fill_reg;
    logic [SW-1:0] r_wsum, l_wsum;
    logic [AW-1:0] r_waddr, l_waddr;
    logic          r_we, l_we;
    pes_pkg::req_t r_rdata, l_rdata;

    // emission state
    pes_pkg::phase_t phase_reg;
    logic [15:0]     timer_reg;
    logic [15:0]     remaining_reg;
    logic [17:0]     total_reg;       // saturates; only total/1000 up to 255 matters
    logic [15:0]     on_time_reg;
    logic            stop_reg;
    pes_pkg::req_t   act_reg;
    logic            act_right_reg;

    // arithmetic scratch
    logic [23:0] x_reg;
    logic [16:0] q_reg, r_reg;
    logic [36:0] sec_prod_reg;

    // per-beat result fields
    logic       acc_reg, done_reg;
    logic [2:0] done_ch_reg;
    logic [7:0] new_lvl_reg;

    // output register
    logic                    m_valid_reg;
    logic [NUM_CHANNELS-1:0] m_relay_reg, m_led_reg;
    logic [6:0]              m_pwm_r_reg, m_pwm_l_reg;
    logic                    m_busy_reg, m_acc_reg, m_done_reg;
    logic [2:0]              m_done_ch_reg;
    logic [7:0]              m_lvl_reg;
    logic [CW-1:0]           m_rcnt_reg, m_lcnt_reg;

    // derived values
    logic [15:0]             per_eff;
    logic                    busy;
    logic                    out_free;
    logic [NUM_CHANNELS-1:0] led_bits;
    logic [6:0]              lvl_cap, pwm_now;
    logic [18:0]             accum_sum;
    logic [8:0]              secs_raw;
    logic [7:0]              secs;
    logic [7:0]              lvl_left;
    logic                    r_full, l_full;

    assign per_eff  = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign busy     = (phase_reg != pes_pkg::PH_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign r_full   = (r_fill_reg >= CW'(QUEUE_DEPTH));
    assign l_full   = (l_fill_reg >= CW'(QUEUE_DEPTH));
    assign ctrl     = pes_pkg::ucode(upc_reg);
    assign s_ready  = (upc_reg == pes_pkg::A_FETCH);

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            led_bits[i] = busy && (int'(act_reg.channel) == i + 1);
        end
    end

    assign lvl_cap   = (drive_reg > pes_pkg::DRIVE_MAX) ? pes_pkg::DRIVE_MAX : drive_reg;
    assign pwm_now   = (phase_reg == pes_pkg::PH_SETTLE || phase_reg == pes_pkg::PH_ON) ?
                       lvl_cap : 7'd0;
    assign accum_sum = {1'b0, total_reg} + {3'b000, on_time_reg};

    // depletion: whole seconds of relay time, capped, at least one for a full period
    always_comb begin
        secs_raw = sec_prod_reg[pes_pkg::RECIP_SHIFT +: 9];
        secs     = (secs_raw > 9'd255) ? 8'hFF : secs_raw[7:0];
        if (secs == 8'd0 && act_reg.intensity != 8'd0 && act_reg.duration >= per_eff) begin
            secs = 8'd1;
        end
        lvl_left = (act_reg.level > secs) ? act_reg.level - secs : 8'd0;
    end

    // tail slot of each ring, wrapped without a divider
    always_comb begin
        r_wsum  = SW'(r_head_reg) + SW'(r_fill_reg);
        l_wsum  = SW'(l_head_reg) + SW'(l_fill_reg);
        r_waddr = (r_wsum >= SW'(QUEUE_DEPTH)) ? AW'(r_wsum - SW'(QUEUE_DEPTH)) : AW'(r_wsum);
        l_waddr = (l_wsum >= SW'(QUEUE_DEPTH)) ? AW'(l_wsum - SW'(QUEUE_DEPTH)) : AW'(l_wsum);
        r_we    = (ctrl.op == pes_pkg::OP_PUSH) && (cmd_reg == pes_pkg::CMD_PUSH_R) && !r_full;
        l_we    = (ctrl.op == pes_pkg::OP_PUSH) && (cmd_reg == pes_pkg::CMD_PUSH_L) && !l_full;
    end

    pes_ram #(.WIDTH(pes_pkg::REQ_W), .DEPTH(QUEUE_DEPTH)) u_right_q (
        .aclk  (aclk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (in_req_reg),
        .raddr (r_head_reg),
        .rdata (r_rdata)
    );

    pes_ram #(.WIDTH(pes_pkg::REQ_W), .DEPTH(QUEUE_DEPTH)) u_left_q (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (in_req_reg),
        .raddr (l_head_reg),
        .rdata (l_rdata)
    );

    // branch conditions
    always_comb begin
        unique case (ctrl.cond)
            pes_pkg::C_NEVER:       jump = 1'b0;
            pes_pkg::C_ALWAYS:      jump = 1'b1;
            pes_pkg::C_NO_BEAT:     jump = !s_valid;
            pes_pkg::C_CMD_PUSH:    jump = (cmd_reg == pes_pkg::CMD_PUSH_R) ||
                                           (cmd_reg == pes_pkg::CMD_PUSH_L);
            pes_pkg::C_CMD_STOP:    jump = (cmd_reg == pes_pkg::CMD_STOP);
            pes_pkg::C_BUSY:        jump = busy;
            pes_pkg::C_QEMPTY:      jump = (r_fill_reg == '0) && (l_fill_reg == '0);
            pes_pkg::C_REM_ZERO:    jump = (remaining_reg == 16'd0);
            pes_pkg::C_SETTLE_SKIP: jump = (on_time_reg == 16'd0) || (settle_reg == 16'd0);
            pes_pkg::C_ONTIME_ZERO: jump = (on_time_reg == 16'd0);
            pes_pkg::C_OFF_ZERO:    jump = (per_eff <= on_time_reg);
            pes_pkg::C_END:         jump = stop_reg ||
                                           ({1'b0, remaining_reg} < {per_eff, 1'b0});
            pes_pkg::C_TIMER_NZ:    jump = (timer_reg != 16'd0);
            pes_pkg::C_PH_SETTLE:   jump = (phase_reg == pes_pkg::PH_SETTLE);
            pes_pkg::C_PH_ON:       jump = (phase_reg == pes_pkg::PH_ON);
            pes_pkg::C_OUT_FREE:    jump = out_free;
            default:                jump = 1'b0;
        endcase
        upc_next = jump ? ctrl.target : upc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= pes_pkg::PERIOD_RST;
            drive_reg  <= pes_pkg::DRIVE_RST;
            settle_reg <= pes_pkg::SETTLE_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                pes_pkg::CFG_PERIOD: period_reg <= cfg_wdata;
                pes_pkg::CFG_DRIVE:  drive_reg  <= cfg_wdata[6:0];
                pes_pkg::CFG_SETTLE: settle_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // beat payload and arithmetic scratch: no reset needed
    always_ff @(posedge aclk) begin
        if (ctrl.op == pes_pkg::OP_FETCH && s_valid) begin
            cmd_reg              <= s_cmd;
            in_req_reg.channel   <= s_channel;
            in_req_reg.intensity <= s_intensity;
            in_req_reg.duration  <= s_duration_ms;
            in_req_reg.level     <= s_pod_level;
        end
        if (ctrl.op == pes_pkg::OP_MUL) begin
            x_reg <= {8'd0, per_eff} * {16'd0, act_reg.intensity};
        end
        // divide by 255 by folding: 256a + b = 255a + (a + b)
        if (ctrl.op == pes_pkg::OP_FOLD0) begin
            q_reg <= {1'b0, x_reg[23:8]};
            r_reg <= {9'd0, x_reg[7:0]} + {1'b0, x_reg[23:8]};
        end else if (ctrl.op == pes_pkg::OP_FOLD) begin
            q_reg <= q_reg + {8'd0, r_reg[16:8]};
            r_reg <= {9'd0, r_reg[7:0]} + {8'd0, r_reg[16:8]};
        end
        if (ctrl.op == pes_pkg::OP_MULSEC) begin
            sec_prod_reg <= {19'd0, total_reg} * {18'd0, pes_pkg::RECIP_1000};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg       <= pes_pkg::A_FETCH;
            r_head_reg    <= '0;
            l_head_reg    <= '0;
            r_fill_reg    <= '0;
            l_fill_reg    <= '0;
            phase_reg     <= pes_pkg::PH_IDLE;
            timer_reg     <= '0;
            remaining_reg <= '0;
            total_reg     <= '0;
            on_time_reg   <= '0;
            stop_reg      <= 1'b0;
            act_reg       <= '0;
            act_right_reg <= 1'b0;
            acc_reg       <= 1'b0;
            done_reg      <= 1'b0;
            done_ch_reg   <= '0;
            new_lvl_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            upc_reg <= upc_next;
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (ctrl.op)
                pes_pkg::OP_FETCH: begin
                    acc_reg     <= 1'b0;
                    done_reg    <= 1'b0;
                    done_ch_reg <= '0;
                    new_lvl_reg <= '0;
                end
                pes_pkg::OP_PUSH: begin
                    if (r_we) begin
                        r_fill_reg <= r_fill_reg + 1'b1;
                    end
                    if (l_we) begin
                        l_fill_reg <= l_fill_reg + 1'b1;
                    end
                    acc_reg <= r_we || l_we;
                end
                pes_pkg::OP_STOP: begin
                    if (busy) begin
                        stop_reg <= 1'b1;
                    end
                end
                pes_pkg::OP_POP_RD: begin
                    // right side first; read data lands next cycle
                    act_right_reg <= (r_fill_reg != '0);
                    if (r_fill_reg != '0) begin
                        r_fill_reg <= r_fill_reg - 1'b1;
                        r_head_reg <= (r_head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head_reg + 1'b1;
                    end else begin
                        l_fill_reg <= l_fill_reg - 1'b1;
                        l_head_reg <= (l_head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : l_head_reg + 1'b1;
                    end
                    stop_reg  <= 1'b0;
                    total_reg <= '0;
                end
                pes_pkg::OP_POP_LD: begin
                    act_reg       <= act_right_reg ? r_rdata : l_rdata;
                    remaining_reg <= act_right_reg ? r_rdata.duration : l_rdata.duration;
                end
                pes_pkg::OP_FIXQ: begin
                    on_time_reg <= q_reg[15:0] + {15'd0, (r_reg >= pes_pkg::DIV_255)};
                end
                pes_pkg::OP_ENTER_SETTLE: begin
                    phase_reg <= pes_pkg::PH_SETTLE;
                    timer_reg <= settle_reg;
                end
                pes_pkg::OP_ENTER_ON: begin
                    phase_reg <= pes_pkg::PH_ON;
                    timer_reg <= on_time_reg;
                end
                pes_pkg::OP_ENTER_OFF: begin
                    phase_reg <= pes_pkg::PH_OFF;
                    timer_reg <= per_eff - on_time_reg;
                end
                pes_pkg::OP_ACCUM: begin
                    total_reg <= accum_sum[18] ? '1 : accum_sum[17:0];
                end
                pes_pkg::OP_SUBREM: begin
                    remaining_reg <= remaining_reg - per_eff;
                end
                pes_pkg::OP_DEC: begin
                    if (timer_reg != 16'd0) begin
                        timer_reg <= timer_reg - 16'd1;
                    end
                end
                pes_pkg::OP_DONE: begin
                    done_reg    <= 1'b1;
                    done_ch_reg <= act_reg.channel;
                    new_lvl_reg <= lvl_left;
                    phase_reg   <= pes_pkg::PH_IDLE;
                    timer_reg   <= '0;
                    stop_reg    <= 1'b0;
                end
                pes_pkg::OP_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // result fields; loaded only together with m_valid_reg
    always_ff @(posedge aclk) begin
        if (ctrl.op == pes_pkg::OP_EMIT && out_free) begin
            m_relay_reg   <= (phase_reg == pes_pkg::PH_ON) ? led_bits : '0;
            m_led_reg     <= led_bits;
            m_pwm_r_reg   <= act_right_reg ? pwm_now : 7'd0;
            m_pwm_l_reg   <= act_right_reg ? 7'd0 : pwm_now;
            m_busy_reg    <= busy;
            m_acc_reg     <= acc_reg;
            m_done_reg    <= done_reg;
            m_done_ch_reg <= done_ch_reg;
            m_lvl_reg     <= new_lvl_reg;
            m_rcnt_reg    <= r_fill_reg;
            m_lcnt_reg    <= l_fill_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_relay_mask    = m_relay_reg;
    assign m_led_mask      = m_led_reg;
    assign m_pwm_right     = m_pwm_r_reg;
    assign m_pwm_left      = m_pwm_l_reg;
    assign m_freq_fixed    = m_busy_reg;
    assign m_busy_res      = m_busy_reg;
    assign m_push_accepted = m_acc_reg;
    assign m_done_res      = m_done_reg;
    assign m_done_channel  = m_done_ch_reg;
    assign m_new_level     = m_lvl_reg;
    assign m_right_count   = m_rcnt_reg;
    assign m_left_count    = m_lcnt_reg;

    // a running emission always sits in a window with ticks left when a beat is taken
    a_window_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && busy) |-> (timer_reg != 16'd0))
        else $error("emission active with expired window at fetch");

    // a finished emission reports idle in the same beat
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_busy_res)
        else $error("done beat reports busy");

    // relay only closes on a channel whose LED is lit
    a_relay_led: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_relay_mask & ~m_led_mask) == '0))
        else $error("relay on without LED");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (r_fill_reg <= CW'(QUEUE_DEPTH)) && (l_fill_reg <= CW'(QUEUE_DEPTH)))
        else $error("queue fill beyond depth");

endmodule

// ===== test/pulse_sequence_checker.sv =====
`timescale 1ns / 100ps
// Checker for pulsed_emitter_burst_sequencer_core: tracks queues, emission windows and
// config writes, predicts every result beat and compares it field by field. Uses pes_pkg.
module pulse_sequence_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [2:0]  s_channel,
    input  logic [7:0]  s_intensity,
    input  logic [15:0] s_duration_ms,
    input  logic [7:0]  s_pod_level,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [5:0]  m_relay_mask,
    input  logic [5:0]  m_led_mask,
    input  logic [6:0]  m_pwm_right,
    input  logic [6:0]  m_pwm_left,
    input  logic        m_freq_fixed,
    input  logic        m_busy_res,
    input  logic        m_push_accepted,
    input  logic        m_done_res,
    input  logic [2:0]  m_done_channel,
    input  logic [7:0]  m_new_level,
    input  logic [4:0]  m_right_count,
    input  logic [4:0]  m_left_count,
    output int          mismatch_count,
    output int          in_flight
);

    localparam int QDEPTH = pes_pkg::QUEUE_DEPTH_DEF;
    localparam int NCH    = pes_pkg::NUM_CHANNELS_DEF;

    typedef enum logic [2:0] {
        WIN_IDLE, WIN_SETTLE, WIN_ON, WIN_OFF, WIN_CLOSE
    } window_t;

    typedef struct {
        logic [NCH-1:0] relay_mask;
        logic [NCH-1:0] led_mask;
        logic [6:0]     pwm_right;
        logic [6:0]     pwm_left;
        logic           freq_fixed;
        logic           busy;
        logic           push_accepted;
        logic           done;
        logic [2:0]     done_channel;
        logic [7:0]     new_level;
        logic [4:0]     right_count;
        logic [4:0]     left_count;
    } emitter_view_t;

    // config shadow
    logic [15:0] cfg_period;
    logic [15:0] cfg_settle;
    logic [6:0]  cfg_drive;

    // request queues and emission state
    pes_pkg::req_t rq_right [QDEPTH];
    pes_pkg::req_t rq_left  [QDEPTH];
    int unsigned   fill_r, fill_l, head_r, head_l;
    window_t       win;
    int unsigned   win_left;
    int unsigned   dur_left;
    int unsigned   on_acc;
    int unsigned   pulse_on;
    bit            stop_pend;
    pes_pkg::req_t cur;
    bit            cur_right;

    emitter_view_t pending_outputs[$];
    emitter_view_t head_view;
    int            fails = 0;

    assign mismatch_count = fails;

    function automatic int unsigned period_eff();
        return (cfg_period == 16'd0) ? 1 : int'(cfg_period);
    endfunction

    // Walk forward from window w, skipping empty ones; 1 means the emission is over.
    function automatic bit open_window(window_t w);
        window_t     nxt;
        int unsigned per;
        int unsigned off_len;
        logic [32:0] sum;
        nxt = w;
        while (1'b1) begin
            per = period_eff();
            case (nxt)
                WIN_SETTLE: begin
                    if (pulse_on != 0 && cfg_settle != 16'd0) begin
                        win = WIN_SETTLE;
                        win_left = cfg_settle;
                        return 1'b0;
                    end
                    nxt = WIN_ON;
                end
                WIN_ON: begin
                    if (pulse_on != 0) begin
                        win = WIN_ON;
                        win_left = pulse_on;
                        return 1'b0;
                    end
                    nxt = WIN_OFF;
                end
                WIN_OFF: begin
                    off_len = (per > pulse_on) ? per - pulse_on : 0;
                    if (off_len != 0) begin
                        win = WIN_OFF;
                        win_left = off_len;
                        return 1'b0;
                    end
                    nxt = WIN_CLOSE;
                end
                default: begin
                    sum = {1'b0, on_acc} + {1'b0, pulse_on};
                    on_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (stop_pend || dur_left < 2 * per)
                        return 1'b1;
                    dur_left = dur_left - per;
                    nxt = WIN_SETTLE;
                end
            endcase
        end
        return 1'b1;
    endfunction

    task automatic reset_emitter();
        cfg_period = pes_pkg::PERIOD_RST;
        cfg_drive  = pes_pkg::DRIVE_RST;
        cfg_settle = pes_pkg::SETTLE_RST;
        for (int i = 0; i < QDEPTH; i++) begin
            rq_right[i] = '0;
            rq_left[i]  = '0;
        end
        fill_r = 0;
        fill_l = 0;
        head_r = 0;
        head_l = 0;
        win = WIN_IDLE;
        win_left = 0;
        dur_left = 0;
        on_acc = 0;
        pulse_on = 0;
        stop_pend = 1'b0;
        cur = '0;
        cur_right = 1'b0;
        pending_outputs.delete();
    endtask

    // One command beat in, the expected result beat queued.
    task automatic advance_emitter(input logic [1:0] cmd, input pes_pkg::req_t rq);
        emitter_view_t  v;
        bit             accepted;
        bit             finished;
        bit             busy;
        logic [2:0]     fin_ch;
        logic [7:0]     fin_lvl;
        int unsigned    secs;
        window_t        nxt;
        logic [NCH-1:0] ch_mask;
        logic [6:0]     drive;
        logic [6:0]     pwm;
        accepted = 1'b0;
        finished = 1'b0;
        fin_ch = '0;
        fin_lvl = '0;
        case (cmd)
            pes_pkg::CMD_PUSH_R: begin
                if (fill_r < QDEPTH) begin
                    rq_right[(head_r + fill_r) % QDEPTH] = rq;
                    fill_r++;
                    accepted = 1'b1;
                end
            end
            pes_pkg::CMD_PUSH_L: begin
                if (fill_l < QDEPTH) begin
                    rq_left[(head_l + fill_l) % QDEPTH] = rq;
                    fill_l++;
                    accepted = 1'b1;
                end
            end
            pes_pkg::CMD_STOP: begin
                if (win != WIN_IDLE)
                    stop_pend = 1'b1;
            end
            pes_pkg::CMD_TICK: begin
                if (win == WIN_IDLE) begin
                    if (fill_r != 0 || fill_l != 0) begin
                        // right side always wins the pop
                        if (fill_r != 0) begin
                            cur = rq_right[head_r];
                            head_r = (head_r + 1) % QDEPTH;
                            fill_r--;
                            cur_right = 1'b1;
                        end else begin
                            cur = rq_left[head_l];
                            head_l = (head_l + 1) % QDEPTH;
                            fill_l--;
                            cur_right = 1'b0;
                        end
                        stop_pend = 1'b0;
                        on_acc = 0;
                        dur_left = cur.duration;
                        pulse_on = (period_eff() * cur.intensity) / 255;
                        if (dur_left == 0) begin
                            finished = 1'b1;
                        end else begin
                            win = WIN_SETTLE;
                            finished = open_window(WIN_SETTLE);
                        end
                    end
                end else begin
                    if (win_left > 0)
                        win_left--;
                    if (win_left == 0) begin
                        case (win)
                            WIN_SETTLE: nxt = WIN_ON;
                            WIN_ON:     nxt = WIN_OFF;
                            default:    nxt = WIN_CLOSE;
                        endcase
                        finished = open_window(nxt);
                    end
                end
                if (finished) begin
                    secs = on_acc / 1000;
                    if (secs > 255)
                        secs = 255;
                    if (secs == 0 && cur.intensity != 8'd0 && cur.duration >= period_eff())
                        secs = 1;
                    fin_lvl = (cur.level > secs) ? 8'(cur.level - secs) : 8'd0;
                    fin_ch = cur.channel;
                    win = WIN_IDLE;
                    win_left = 0;
                    stop_pend = 1'b0;
                end
            end
            default: ;
        endcase

        busy = (win != WIN_IDLE);
        ch_mask = '0;
        if (busy && cur.channel >= 1 && cur.channel <= NCH)
            ch_mask[cur.channel - 1] = 1'b1;
        drive = (cfg_drive > pes_pkg::DRIVE_MAX) ? pes_pkg::DRIVE_MAX : cfg_drive;
        pwm = (win == WIN_SETTLE || win == WIN_ON) ? drive : 7'd0;

        v.relay_mask    = (win == WIN_ON) ? ch_mask : '0;
        v.led_mask      = ch_mask;
        v.pwm_right     = cur_right ? pwm : 7'd0;
        v.pwm_left      = cur_right ? 7'd0 : pwm;
        v.freq_fixed    = busy;
        v.busy          = busy;
        v.push_accepted = accepted;
        v.done          = finished;
        v.done_channel  = fin_ch;
        v.new_level     = fin_lvl;
        v.right_count   = 5'(fill_r);
        v.left_count    = 5'(fill_l);
        pending_outputs.push_back(v);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_emitter();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_outputs.size() == 0) begin
                    $error("result beat with no command beat outstanding");
                    fails++;
                end else begin
                    head_view = pending_outputs.pop_front();
                    check_field("relay_mask", head_view.relay_mask, m_relay_mask);
                    check_field("led_mask", head_view.led_mask, m_led_mask);
                    check_field("pwm_right", head_view.pwm_right, m_pwm_right);
                    check_field("pwm_left", head_view.pwm_left, m_pwm_left);
                    check_field("freq_fixed", head_view.freq_fixed, m_freq_fixed);
                    check_field("busy_res", head_view.busy, m_busy_res);
                    check_field("push_accepted", head_view.push_accepted, m_push_accepted);
                    check_field("done_res", head_view.done, m_done_res);
                    check_field("done_channel", head_view.done_channel, m_done_channel);
                    check_field("new_level", head_view.new_level, m_new_level);
                    check_field("right_count", head_view.right_count, m_right_count);
                    check_field("left_count", head_view.left_count, m_left_count);
                end
            end
            if (cfg_wen) begin
                case (cfg_index)
                    pes_pkg::CFG_PERIOD: cfg_period = cfg_wdata;
                    pes_pkg::CFG_DRIVE:  cfg_drive  = cfg_wdata[6:0];
                    pes_pkg::CFG_SETTLE: cfg_settle = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                advance_emitter(s_cmd, pes_pkg::req_t'({s_channel, s_intensity,
                                                        s_duration_ms, s_pod_level}));
        end
        in_flight = pending_outputs.size();
    end

endmodule

// ===== test/tb_pulsed_emitter_burst_sequencer_core.sv =====
`timescale 1ns / 100ps
// Top of the pulsed_emitter_burst_sequencer_core bench: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on pes_pkg and pulse_sequence_checker.
module tb_pulsed_emitter_burst_sequencer_core;

    localparam int CYCLE_LIMIT = 800000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BEATS = 550;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [1:0]  cfg_index = pes_pkg::CFG_PERIOD;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = pes_pkg::CMD_TICK;
    logic [2:0]  s_channel = '0;
    logic [7:0]  s_intensity = '0;
    logic [15:0] s_duration_ms = '0;
    logic [7:0]  s_pod_level = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_relay_mask;
    logic [5:0]  m_led_mask;
    logic [6:0]  m_pwm_right;
    logic [6:0]  m_pwm_left;
    logic        m_freq_fixed;
    logic        m_busy_res;
    logic        m_push_accepted;
    logic        m_done_res;
    logic [2:0]  m_done_channel;
    logic [7:0]  m_new_level;
    logic [4:0]  m_right_count;
    logic [4:0]  m_left_count;

    int          mismatches;
    int          in_flight;
    int          beats_sent = 0;
    int          results_seen = 0;
    logic        last_busy = 1'b0;
    logic        last_done = 1'b0;
    logic [4:0]  last_rc = '0;
    logic [4:0]  last_lc = '0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_asks = 0;
    int          hold_done = 0;
    int          hold_left = 0;
    int          cycle_count = 0;
    int          per_now = 1;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    pulsed_emitter_burst_sequencer_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_channel       (s_channel),
        .s_intensity     (s_intensity),
        .s_duration_ms   (s_duration_ms),
        .s_pod_level     (s_pod_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_relay_mask    (m_relay_mask),
        .m_led_mask      (m_led_mask),
        .m_pwm_right     (m_pwm_right),
        .m_pwm_left      (m_pwm_left),
        .m_freq_fixed    (m_freq_fixed),
        .m_busy_res      (m_busy_res),
        .m_push_accepted (m_push_accepted),
        .m_done_res      (m_done_res),
        .m_done_channel  (m_done_channel),
        .m_new_level     (m_new_level),
        .m_right_count   (m_right_count),
        .m_left_count    (m_left_count)
    );

    pulse_sequence_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_channel       (s_channel),
        .s_intensity     (s_intensity),
        .s_duration_ms   (s_duration_ms),
        .s_pod_level     (s_pod_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_relay_mask    (m_relay_mask),
        .m_led_mask      (m_led_mask),
        .m_pwm_right     (m_pwm_right),
        .m_pwm_left      (m_pwm_left),
        .m_freq_fixed    (m_freq_fixed),
        .m_busy_res      (m_busy_res),
        .m_push_accepted (m_push_accepted),
        .m_done_res      (m_done_res),
        .m_done_channel  (m_done_channel),
        .m_new_level     (m_new_level),
        .m_right_count   (m_right_count),
        .m_left_count    (m_left_count),
        .mismatch_count  (mismatches),
        .in_flight       (in_flight)
    );

    // result side: random stalls, plus a long hold-off whenever one is asked for
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_done != hold_asks) begin
            hold_done <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            last_busy <= m_busy_res;
            last_done <= m_done_res;
            last_rc <= m_right_count;
            last_lc <= m_left_count;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_pulsed_emitter_burst_sequencer_core NOT OK");
            $finish;
        end
    end

    task automatic send_beat(input logic [1:0] cmd, input logic [2:0] ch,
                             input logic [7:0] inten, input logic [15:0] dur,
                             input logic [7:0] lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_channel <= ch;
        s_intensity <= inten;
        s_duration_ms <= dur;
        s_pod_level <= lvl;
        do
            @(posedge aclk);
        while (!s_ready);
        beats_sent++;
    endtask

    // random request fields; ignored by the block for ticks and stops
    task automatic send_command(input logic [1:0] cmd);
        int          pick;
        logic [7:0]  inten;
        logic [15:0] dur;
        logic [7:0]  lvl;
        pick = $urandom_range(99);
        inten = (pick < 20) ? 8'd0 : (pick < 40) ? 8'd255 : 8'($urandom_range(255));
        pick = $urandom_range(99);
        dur = (pick < 8) ? 16'($urandom_range(65535)) : 16'($urandom_range(3 * per_now));
        pick = $urandom_range(99);
        lvl = (pick < 15) ? 8'd0 : 8'($urandom_range(255));
        send_beat(cmd, 3'($urandom_range(7)), inten, dur, lvl);
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_seen != beats_sent)
            @(posedge aclk);
    endtask

    task automatic configure(input logic [15:0] period, input logic [6:0] drive,
                             input logic [15:0] settle);
        wait_results();
        // all results are in, so the microprogram is back at its fetch step before the writes
        repeat (30) @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_index <= pes_pkg::CFG_PERIOD;
        cfg_wdata <= period;
        @(posedge aclk);
        cfg_index <= pes_pkg::CFG_DRIVE;
        cfg_wdata <= {9'd0, drive};
        @(posedge aclk);
        cfg_index <= pes_pkg::CFG_SETTLE;
        cfg_wdata <= settle;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        per_now = (period == 16'd0) ? 1 : int'(period);
    endtask

    // tick until both queues are empty and nothing emits; optionally cut emissions short
    task automatic run_out(input bit cut);
        bit stop_sent;
        stop_sent = 1'b0;
        wait_results();
        while (last_busy || last_rc != 0 || last_lc != 0) begin
            if (cut && last_busy && !stop_sent) begin
                send_command(pes_pkg::CMD_STOP);
                stop_sent = 1'b1;
            end
            send_command(pes_pkg::CMD_TICK);
            wait_results();
            if (last_done || !last_busy)
                stop_sent = 1'b0;
        end
    endtask

    task automatic random_phase(input int beats, input int pause_at, input int hold_at);
        int pick;
        for (int n = 0; n < beats; n++) begin
            if (n == hold_at) begin
                // sender keeps pushing while results are held back
                hold_asks <= hold_asks + 1;
                repeat (20) send_command(pes_pkg::CMD_PUSH_L);
            end
            if (n == pause_at)
                wait_results();
            pick = $urandom_range(99);
            if (pick < 5) begin
                repeat ($urandom_range(1, 6))
                    send_command($urandom_range(1) ? pes_pkg::CMD_PUSH_R : pes_pkg::CMD_PUSH_L);
            end else if (pick < 14) begin
                send_command(pes_pkg::CMD_PUSH_R);
            end else if (pick < 22) begin
                send_command(pes_pkg::CMD_PUSH_L);
            end else if (pick < 96) begin
                send_command(pes_pkg::CMD_TICK);
            end else begin
                send_command(pes_pkg::CMD_STOP);
            end
        end
    endtask

    initial begin
        send_idle_pct = 18;
        recv_idle_pct <= 63;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: idle tick and stop, zero-length pop
        send_beat(pes_pkg::CMD_TICK, 3'd0, 8'd0, 16'd0, 8'd0);
        send_beat(pes_pkg::CMD_STOP, 3'd7, 8'd255, 16'hFFFF, 8'd255);
        send_beat(pes_pkg::CMD_PUSH_R, 3'd2, 8'd255, 16'd0, 8'd9);
        send_beat(pes_pkg::CMD_TICK, 3'd0, 8'd0, 16'd0, 8'd0);

        configure(16'd10, 7'd100, 16'd2);
        send_beat(pes_pkg::CMD_PUSH_R, 3'd1, 8'd255, 16'd25, 8'd200);
        send_beat(pes_pkg::CMD_PUSH_L, 3'd6, 8'd0, 16'd30, 8'd0);
        send_beat(pes_pkg::CMD_PUSH_R, 3'd0, 8'd128, 16'd0, 8'd255);
        send_beat(pes_pkg::CMD_PUSH_L, 3'd7, 8'd1, 16'd10, 8'd5);
        send_beat(pes_pkg::CMD_PUSH_R, 3'd3, 8'd77, 16'd10, 8'd0);
        send_beat(pes_pkg::CMD_PUSH_L, 3'd4, 8'd200, 16'd12, 8'd255);
        run_out(1'b0);
        // maximal duration, stopped partway through a period
        send_beat(pes_pkg::CMD_PUSH_R, 3'd5, 8'd180, 16'hFFFF, 8'd128);
        repeat (30) send_command(pes_pkg::CMD_TICK);
        send_command(pes_pkg::CMD_STOP);
        send_command(pes_pkg::CMD_STOP);
        run_out(1'b1);

        // register extremes, zero-length requests only
        configure(16'hFFFF, 7'h7F, 16'hFFFF);
        send_beat(pes_pkg::CMD_PUSH_R, 3'd6, 8'd255, 16'd0, 8'd1);
        send_beat(pes_pkg::CMD_PUSH_L, 3'd1, 8'd0, 16'd0, 8'd0);
        run_out(1'b0);

        // ten full on-periods: depletion of two seconds
        configure(16'd200, 7'd100, 16'd0);
        send_beat(pes_pkg::CMD_PUSH_L, 3'd2, 8'd255, 16'd2000, 8'd200);
        run_out(1'b0);

        configure(16'($urandom_range(2, 24)), 7'h7F, 16'd0);
        random_phase(PHASE_BEATS, 400, 250);
        run_out(1'b1);

        configure(16'd0, 7'd0, 16'd3);
        send_idle_pct = 63;
        recv_idle_pct <= 18;
        random_phase(PHASE_BEATS, 275, -1);

        // no run-out here: config changes while an emission may be running
        configure(16'($urandom_range(1, 30)), 7'($urandom_range(127)),
                  16'($urandom_range(5)));
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        random_phase(PHASE_BEATS, -1, -1);

        wait_results();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && in_flight == 0)
            $display("tb_pulsed_emitter_burst_sequencer_core OK");
        else
            $display("tb_pulsed_emitter_burst_sequencer_core NOT OK");
        $finish;
    end

endmodule
